// File: rtl/srr_pkg.sv
// Shared types and constants for the serial ROM read slave.
package srr_pkg;

   // Store and address sizes
   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int ADDR_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int CNT_W     = 5;
   localparam int LOAD_AW   = 16;

   // Item command codes
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Serial phase
   typedef enum logic [1:0] {
      PH_ADDR = 2'd0,
      PH_DATA = 2'd1,
      PH_IDLE = 2'd2
   } srr_phase_type;

   // What the output stage does with an item
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_IDLE  = 2'd1,
      OP_FETCH = 2'd2,
      OP_SHIFT = 2'd3
   } srr_op_type;

   // Item handed from the control stage to the output stage
   typedef struct packed {
      logic       valid;
      srr_op_type op;
      logic       done;
   } srr_stage_type;

endpackage

// File: rtl/srr_chan_if.sv
// Valid/ready channel interfaces for request and response items.
interface srr_req_if
   import srr_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic                 mosi_bit;
   logic [LOAD_AW-1:0]   load_address;
   logic [BYTE_BITS-1:0] load_data;

   modport source (output valid, command, mosi_bit, load_address, load_data, input ready);
   modport sink   (input valid, command, mosi_bit, load_address, load_data, output ready);
endinterface

interface srr_rsp_if;
   logic valid;
   logic ready;
   logic miso_level;
   logic miso_updated;
   logic byte_done;

   modport source (output valid, miso_level, miso_updated, byte_done, input ready);
   modport sink   (input valid, miso_level, miso_updated, byte_done, output ready);
endinterface

// File: rtl/serial_rom_read_slave.sv
// Serial ROM read slave top level.
// An accepted item is registered in the stage register and then in the response register;
// the response is valid once the item sits in the response register.
// Throughput: one item per cycle while responses are taken; the store is read once at the
// accept edge of the last address bit and the byte is held in the store's read register.
// Reset (synchronous, active high) clears phase, counters, line level and valids;
// the byte store has no reset and holds whatever was loaded.
module serial_rom_read_slave
   import srr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   srr_req_if.sink   req_ch,
   srr_rsp_if.source rsp_ch
);

   srr_stage_type        stage;
   logic                 stage_ready;
   logic                 wr_en;
   logic [MEM_AW-1:0]    wr_addr;
   logic [BYTE_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [MEM_AW-1:0]    rd_addr;
   logic [BYTE_BITS-1:0] rd_data;

   srr_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .stage_ready (stage_ready),
      .stage       (stage),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   srr_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srr_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .rd_data     (rd_data),
      .stage_ready (stage_ready),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTHESIS
   // A store read is followed by a fetch item in the stage register
   assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (stage.valid && stage.op == OP_FETCH))
      else $error("fetch item missing after store read");

   // A stalled stage item is never lost
   assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !stage_ready) |=> stage.valid)
      else $error("stage item dropped while stalled");

   // A finished byte always comes with a new data bit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.byte_done) |-> rsp_ch.miso_updated)
      else $error("byte done without data bit");

   // No read and write are issued by the same item
   assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("read and write in the same cycle");
`endif

endmodule

// File: rtl/srr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/srr_ctl.sv
// Control stage: address shifting, phase tracking, store reads and loads.
module srr_ctl
   import srr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   srr_req_if.sink           req_ch,
   input  logic              stage_ready,
   output srr_stage_type     stage,
   output logic              wr_en,
   output logic [MEM_AW-1:0] wr_addr,
   output logic [BYTE_BITS-1:0] wr_data,
   output logic              rd_en,
   output logic [MEM_AW-1:0] rd_addr
);

   srr_phase_type          phase_ff, phase_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   srr_stage_type          stage_ff, stage_in;
   logic                   accept;
   logic                   is_edge;
   logic [ADDR_BITS-1:0]   addr_shift;
   logic [CNT_W-1:0]       cnt_inc;
   logic                   addr_full;
   logic                   byte_full;
   srr_op_type             op;
   logic [ADDR_BITS+MEM_AW-1:0] rd_ext;
   logic [LOAD_AW+MEM_AW-1:0]   wr_ext;

   // Take an item whenever the stage register is free or draining
   assign req_ch.ready = !stage_ff.valid || stage_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_edge      = (req_ch.command == CMD_EDGE);

   assign addr_shift = {addr_ff[ADDR_BITS-2:0], req_ch.mosi_bit};
   assign cnt_inc    = cnt_ff + CNT_W'(1);
   assign addr_full  = (cnt_inc == CNT_W'(ADDR_BITS));
   assign byte_full  = (cnt_inc == CNT_W'(BYTE_BITS));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && is_edge) begin
         unique case (phase_ff)
            PH_ADDR: if (addr_full) phase_in = PH_DATA;
            PH_DATA: if (byte_full) phase_in = PH_IDLE;
            default: phase_in = PH_ADDR;
         endcase
      end
   end

   // Address, count and operation for this item
   always_comb begin
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      op      = OP_LOAD;
      if (is_edge) begin
         unique case (phase_ff)
            PH_ADDR: begin
               addr_in = addr_shift;
               if (addr_full) begin
                  op     = OP_FETCH;
                  cnt_in = CNT_W'(1);
               end else begin
                  op     = OP_IDLE;
                  cnt_in = cnt_inc;
               end
            end
            PH_DATA: begin
               op = OP_SHIFT;
               if (byte_full) begin
                  cnt_in  = '0;
                  addr_in = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            default: op = OP_IDLE;
         endcase
      end
   end

   // Stage register: load on accept, drop when taken downstream
   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.op    = op;
         stage_in.done  = is_edge && (phase_ff == PH_DATA) && byte_full;
      end else if (stage_ready) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ADDR;
         addr_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            addr_ff <= addr_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op   <= stage_in.op;
      stage_ff.done <= stage_in.done;
   end

   // Store accesses happen at accept time, in item order
   assign rd_ext  = {{MEM_AW{1'b0}}, addr_shift};
   assign wr_ext  = {{MEM_AW{1'b0}}, req_ch.load_address};
   assign rd_en   = accept && (op == OP_FETCH);
   assign rd_addr = rd_ext[MEM_AW-1:0];
   assign wr_en   = accept && !is_edge;
   assign wr_addr = wr_ext[MEM_AW-1:0];
   assign wr_data = req_ch.load_data;

   assign stage = stage_ff;

endmodule

// File: rtl/srr_out.sv
// Output stage: data byte shifting, line level and response register.
module srr_out
   import srr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  srr_stage_type        stage,
   input  logic [BYTE_BITS-1:0] rd_data,
   output logic                 stage_ready,
   srr_rsp_if.source            rsp_ch
);

   logic [BYTE_BITS-1:0] dshift_ff, dshift_in;
   logic                 miso_ff, miso_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 updated_ff;
   logic                 done_ff;
   logic                 take;

   assign stage_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take        = stage.valid && stage_ready;

   // Drive the next data bit from the fetched byte or the shift register
   always_comb begin
      dshift_in = dshift_ff;
      miso_in   = miso_ff;
      case (stage.op)
         OP_FETCH: begin
            miso_in   = rd_data[BYTE_BITS-1];
            dshift_in = {rd_data[BYTE_BITS-2:0], 1'b0};
         end
         OP_SHIFT: begin
            miso_in   = dshift_ff[BYTE_BITS-1];
            dshift_in = {dshift_ff[BYTE_BITS-2:0], 1'b0};
         end
         default: ;
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         miso_ff      <= 1'b0;
         dshift_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            miso_ff   <= miso_in;
            dshift_ff <= dshift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         updated_ff <= (stage.op == OP_FETCH) || (stage.op == OP_SHIFT);
         done_ff    <= stage.done;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.miso_level   = miso_ff;
   assign rsp_ch.miso_updated = updated_ff;
   assign rsp_ch.byte_done    = done_ff;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the serial ROM read slave: scoreboard, drivers and run control.
`timescale 1ns / 100ps

module testbench;
   import srr_pkg::*;

   // Address bits, seven more data bits, idle edge
   localparam int FRAME_EDGES  = ADDR_BITS + BYTE_BITS;
   localparam int TOTAL_ITEMS  = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 400_000;

   typedef struct packed {
      logic miso_level;
      logic miso_updated;
      logic byte_done;
   } miso_result_type;

   // Mirror of the slave: serial state machine plus byte store, one expected result per item
   class rom_read_scoreboard;
      bit [BYTE_BITS-1:0] rom_image [MEM_DEPTH];
      srr_phase_type      phase;
      logic [ADDR_BITS-1:0] addr_shift;
      logic [BYTE_BITS-1:0] data_shift;
      logic [CNT_W-1:0]     bit_cnt;
      logic                 line_level;
      miso_result_type      expected_bits[$];
      int                   mismatches;

      function new();
         phase      = PH_ADDR;
         addr_shift = '0;
         data_shift = '0;
         bit_cnt    = '0;
         line_level = 1'b0;
         mismatches = 0;
      endfunction

      // Advance the mirror by one accepted item and queue what the slave should answer
      function void note_request(logic cmd, logic mosi, logic [LOAD_AW-1:0] addr,
                                 logic [BYTE_BITS-1:0] data);
         miso_result_type res;
         res.miso_updated = 1'b0;
         res.byte_done    = 1'b0;
         if (cmd == CMD_LOAD) begin
            rom_image[addr] = data;
         end else begin
            if (phase == PH_ADDR) begin
               addr_shift = {addr_shift[ADDR_BITS-2:0], mosi};
               bit_cnt    = bit_cnt + 1'b1;
               if (bit_cnt == ADDR_BITS) begin
                  data_shift = rom_image[addr_shift];
                  phase      = PH_DATA;
                  bit_cnt    = '0;
               end
            end else if (phase != PH_DATA) begin
               // idle edge only re-arms the address phase
               phase = PH_ADDR;
            end
            if (phase == PH_DATA) begin
               line_level       = data_shift[BYTE_BITS-1];
               data_shift       = data_shift << 1;
               bit_cnt          = bit_cnt + 1'b1;
               res.miso_updated = 1'b1;
               if (bit_cnt == BYTE_BITS) begin
                  res.byte_done = 1'b1;
                  bit_cnt       = '0;
                  data_shift    = '0;
                  addr_shift    = '0;
                  phase         = PH_IDLE;
               end
            end
         end
         res.miso_level = line_level;
         expected_bits.push_back(res);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(logic level, logic updated, logic done);
         miso_result_type exp_res;
         if (expected_bits.size() == 0) begin
            $error("unexpected result: miso_level %0b miso_updated %0b byte_done %0b",
                   level, updated, done);
            mismatches++;
         end else begin
            exp_res = expected_bits.pop_front();
            if (level !== exp_res.miso_level) begin
               $error("miso_level: expected %0b, got %0b", exp_res.miso_level, level);
               mismatches++;
            end
            if (updated !== exp_res.miso_updated) begin
               $error("miso_updated: expected %0b, got %0b", exp_res.miso_updated, updated);
               mismatches++;
            end
            if (done !== exp_res.byte_done) begin
               $error("byte_done: expected %0b, got %0b", exp_res.byte_done, done);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_bits.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   srr_req_if req_bus ();
   srr_rsp_if rsp_bus ();

   serial_rom_read_slave i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rom_read_scoreboard sb;

   bit idle_on       = 1'b1;
   bit hold_off_req  = 1'b0;
   bit hold_off_done = 1'b0;
   int items_sent    = 0;

   // Stimulus-side view of the serial frame, kept so that no fetch hits an unloaded entry
   int                   serial_pos = 0;
   logic [ADDR_BITS-1:0] addr_accum = '0;
   bit                   loaded_map [MEM_DEPTH];
   logic [LOAD_AW-1:0]   loaded_addrs[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one item, with an occasional gap before it, and hold it until accepted
   task automatic send_item(input logic cmd, input logic mosi, input logic [LOAD_AW-1:0] addr,
                            input logic [BYTE_BITS-1:0] data);
      if (idle_on && $urandom_range(0, 99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.mosi_bit     <= mosi;
      req_bus.load_address <= addr;
      req_bus.load_data    <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(cmd, mosi, addr, data);
      items_sent++;
   endtask

   task automatic load_byte(input logic [LOAD_AW-1:0] addr, input logic [BYTE_BITS-1:0] data);
      send_item(CMD_LOAD, 1'($urandom), addr, data);
      if (!loaded_map[addr]) begin
         loaded_map[addr] = 1'b1;
         loaded_addrs.push_back(addr);
      end
   endtask

   // Send one serial clock edge; load the target first if this edge would fetch an empty entry
   task automatic serial_edge(input logic mosi);
      logic [ADDR_BITS-1:0] target;
      target = {addr_accum[ADDR_BITS-2:0], mosi};
      if (serial_pos == ADDR_BITS - 1 && !loaded_map[target])
         load_byte(target, BYTE_BITS'($urandom));
      send_item(CMD_EDGE, mosi, LOAD_AW'($urandom), BYTE_BITS'($urandom));
      if (serial_pos < ADDR_BITS)
         addr_accum = target;
      serial_pos = (serial_pos + 1) % FRAME_EDGES;
   endtask

   // Run one full read frame of the given address, with loads sprinkled in
   task automatic read_byte(input logic [ADDR_BITS-1:0] addr);
      int i;
      while (serial_pos != 0) serial_edge(1'($urandom));
      for (i = 0; i < FRAME_EDGES; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            if ($urandom_range(0, 1))
               load_byte(addr, BYTE_BITS'($urandom));
            else
               load_byte(LOAD_AW'($urandom), BYTE_BITS'($urandom));
         end
         serial_edge(i < ADDR_BITS ? addr[ADDR_BITS-1-i] : 1'($urandom));
      end
   endtask

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.miso_level, rsp_bus.miso_updated, rsp_bus.byte_done);
   end

   // Drive result-side ready: random stalls, one long hold-off on request
   initial begin : rsp_ready_drive
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 99) < 15) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Main sequence
   initial begin : stimulus
      int                   pick;
      int                   n;
      int                   i;
      logic [ADDR_BITS-1:0] rd_addr;
      sb = new();
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_EDGE;
      req_bus.mosi_bit     <= 1'b0;
      req_bus.load_address <= '0;
      req_bus.load_data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme addresses and bytes, then a top-address read that
      // gets its entry overwritten mid-byte (the fetched byte must not change)
      load_byte(16'h0000, 8'h00);
      load_byte(16'hFFFF, 8'hFF);
      for (i = 0; i < FRAME_EDGES; i++) begin
         if (i == ADDR_BITS + 2)
            load_byte(16'hFFFF, 8'h96);
         serial_edge(1'b1);
      end

      // Random: mostly well-formed reads, some bare loads, some stray edges
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent > 250)
            hold_off_req = 1'b1;
         idle_on = !(items_sent >= 450 && items_sent < 700);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(0, 99);
            if (n < 10)
               rd_addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else if (n < 45 || loaded_addrs.size() == 0)
               rd_addr = ADDR_BITS'($urandom);
            else
               rd_addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
            read_byte(rd_addr);
         end else if (pick < 85) begin
            load_byte(LOAD_AW'($urandom), BYTE_BITS'($urandom));
         end else begin
            n = $urandom_range(1, 30);
            repeat (n) serial_edge(1'($urandom));
         end
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding results
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
